// ----- rtl/dark_pixel_bounding_box_unit_macros.svh -----
// assertion macros used by the bounding box tracker
`ifndef DARK_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH
`define DARK_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DPBB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DPBB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dpbb_pkg.sv -----
// shared types and constants of the dark pixel bounding box unit
package dpbb_pkg;

    localparam int DEF_MAX_DIM   = 4096;
    localparam int PIX_W         = 8;
    localparam int CFG_DIM_W     = 13;
    localparam int FIELD_W       = 12;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 4;
    localparam int REG_IDX_W     = 2;

    localparam logic [PIX_W-1:0]     DEF_THRESHOLD    = 8'd220;
    localparam logic [CFG_DIM_W-1:0] DEF_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] DEF_FRAME_HEIGHT = 13'd480;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0]     threshold;
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] height;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] top;
        logic [FIELD_W-1:0] left;
    } box_t;

endpackage

// ----- rtl/dpbb_cfg.sv -----
// apb configuration registers: threshold and frame size
module dpbb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpbb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dpbb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dpbb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output dpbb_pkg::cfg_t                      cfg
);
    import dpbb_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[APB_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_THRESHOLD:    cfg_next.threshold    = pwdata[PIX_W-1:0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[CFG_DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= DEF_THRESHOLD;
            cfg_reg.frame_width  <= DEF_FRAME_WIDTH;
            cfg_reg.frame_height <= DEF_FRAME_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_THRESHOLD:    prdata = APB_DATA_W'(cfg_reg.threshold);
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/dpbb_in_stage.sv -----
// input register for the pixel stream
module dpbb_in_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dpbb_pkg::PIX_W-1:0]   s_tdata,
    output logic                         pix_valid,
    output logic [dpbb_pkg::PIX_W-1:0]   pix,
    input  logic                         consume
);
    import dpbb_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] pix_reg;

    assign s_tready   = !valid_reg || consume;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pix_reg <= s_tdata;
        end
    end

    assign pix_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

// ----- rtl/dpbb_tracker.sv -----
// raster counters, extreme tracking and box formation at frame end
module dpbb_tracker #(
    parameter int MAX_DIM = dpbb_pkg::DEF_MAX_DIM
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dpbb_pkg::cfg_t               cfg,
    input  logic                         pix_valid,
    input  logic [dpbb_pkg::PIX_W-1:0]   pix,
    output logic                         consume,
    input  logic                         out_free,
    output logic                         box_load,
    output dpbb_pkg::box_t               box
);
    import dpbb_pkg::*;
`include "dark_pixel_bounding_box_unit_macros.svh"

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;

    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic [CW-1:0] min_col_reg, min_col_next, max_col_reg, max_col_next;
    logic [CW-1:0] min_row_reg, min_row_next, max_row_reg, max_row_next;
    logic          seen_reg, seen_next;

    logic [DW-1:0] fw_ext, fh_ext, w_eff, h_eff;
    logic          last_col, last_row, frame_end, drawn;
    logic [CW-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;
    logic          seen_upd;
    logic [CW-1:0] span_col, span_row;
    logic [CW+FIELD_W-1:0] left_ext, top_ext, width_ext, height_ext;

    assign fw_ext = DW'(cfg.frame_width);
    assign fh_ext = DW'(cfg.frame_height);

    // zero acts as one, oversize saturates
    always_comb
    begin
        w_eff = fw_ext;
        if (fw_ext == '0)
            w_eff = DW'(1);
        else if (fw_ext > DW'(MAX_DIM))
            w_eff = DW'(MAX_DIM);
        h_eff = fh_ext;
        if (fh_ext == '0)
            h_eff = DW'(1);
        else if (fh_ext > DW'(MAX_DIM))
            h_eff = DW'(MAX_DIM);
    end

    assign last_col  = (DW'(col_reg) + DW'(1)) >= w_eff;
    assign last_row  = (DW'(row_reg) + DW'(1)) >= h_eff;
    assign frame_end = last_col && last_row;

    // a frame end needs room in the result register
    assign consume  = pix_valid && (!frame_end || out_free);
    assign box_load = consume && frame_end;

    assign drawn = pix < cfg.threshold;

    assign min_col_upd = (drawn && (!seen_reg || col_reg < min_col_reg)) ? col_reg : min_col_reg;
    assign max_col_upd = (drawn && (!seen_reg || col_reg > max_col_reg)) ? col_reg : max_col_reg;
    assign min_row_upd = (drawn && (!seen_reg || row_reg < min_row_reg)) ? row_reg : min_row_reg;
    assign max_row_upd = (drawn && (!seen_reg || row_reg > max_row_reg)) ? row_reg : max_row_reg;
    assign seen_upd    = seen_reg || drawn;

    assign span_col = max_col_upd - min_col_upd;
    assign span_row = max_row_upd - min_row_upd;

    assign left_ext   = {{FIELD_W{1'b0}}, min_col_upd};
    assign top_ext    = {{FIELD_W{1'b0}}, min_row_upd};
    assign width_ext  = {{FIELD_W{1'b0}}, span_col};
    assign height_ext = {{FIELD_W{1'b0}}, span_row};

    always_comb
    begin
        box.found  = seen_upd;
        box.left   = seen_upd ? left_ext[FIELD_W-1:0]   : '0;
        box.top    = seen_upd ? top_ext[FIELD_W-1:0]    : '0;
        box.width  = seen_upd ? width_ext[FIELD_W-1:0]  : '0;
        box.height = seen_upd ? height_ext[FIELD_W-1:0] : '0;
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        seen_next    = seen_reg;
        if (consume)
        begin
            if (frame_end)
            begin
                col_next     = '0;
                row_next     = '0;
                min_col_next = '1;
                max_col_next = '0;
                min_row_next = '1;
                max_row_next = '0;
                seen_next    = 1'b0;
            end
            else
            begin
                min_col_next = min_col_upd;
                max_col_next = max_col_upd;
                min_row_next = min_row_upd;
                max_row_next = max_row_upd;
                seen_next    = seen_upd;
                if (!last_col)
                begin
                    col_next = col_reg + CW'(1);
                end
                else
                begin
                    col_next = '0;
                    row_next = row_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            seen_reg    <= seen_next;
        end
    end

    `DPBB_ASSERT_IMPL(a_col_order, clk, rst_n, seen_reg, min_col_reg <= max_col_reg, "column extremes out of order")
    `DPBB_ASSERT_IMPL(a_row_order, clk, rst_n, seen_reg, min_row_reg <= max_row_reg, "row extremes out of order")
    `DPBB_ASSERT_NEXT(a_frame_clear, clk, rst_n, box_load, col_reg == '0 && row_reg == '0 && !seen_reg, "tracking state not cleared after frame")
    `DPBB_ASSERT_IMPL(a_empty_box, clk, rst_n, box_load && !box.found, box.left == '0 && box.top == '0 && box.width == '0 && box.height == '0, "empty frame gave a nonzero box")

endmodule

// ----- rtl/dpbb_out_reg.sv -----
// result register driving the box stream
module dpbb_out_reg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              box_load,
    input  dpbb_pkg::box_t                    box,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*dpbb_pkg::FIELD_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import dpbb_pkg::*;

    logic valid_reg;
    logic valid_next;
    box_t box_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = box_load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            box_reg <= box;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {box_reg.height, box_reg.width, box_reg.top, box_reg.left};
    assign m_tuser  = box_reg.found;

endmodule

// ----- rtl/dark_pixel_bounding_box_unit.sv -----
// Dark pixel bounding box unit: takes 8-bit grayscale pixels in raster order, one item
// per clock, counts column and row from the configured frame size and tracks the
// extremes of pixels below the threshold. After the last pixel of each frame it sends
// one item with left, top, width (right minus left) and height (bottom minus top) and a
// found flag; an empty frame gives found 0 and an all-zero box. Every pixel passes
// through a single compare-and-update stage between the input register and the
// result register, which loads the box when the last pixel leaves the input register.
// Input is stalled only when a frame ends while the previous box has not been taken.
module dark_pixel_bounding_box_unit #(
    parameter int MAX_DIM = dpbb_pkg::DEF_MAX_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpbb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dpbb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dpbb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dpbb_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel_value
    // box stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*dpbb_pkg::FIELD_W-1:0]    m_tdata,   // box_left, box_top, box_width, box_height
    output logic                              m_tuser    // found_any
);
    import dpbb_pkg::*;

    cfg_t             cfg;
    logic             pix_valid;
    logic [PIX_W-1:0] pix;
    logic             consume;
    logic             out_free;
    logic             box_load;
    box_t             box;

    dpbb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpbb_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .pix_valid (pix_valid),
        .pix       (pix),
        .consume   (consume)
    );

    dpbb_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix       (pix),
        .consume   (consume),
        .out_free  (out_free),
        .box_load  (box_load),
        .box       (box)
    );

    dpbb_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_load (box_load),
        .box      (box),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
